FILE: design/sdf_pkg.sv
// Shared types and constants for the sliding-window duplicate filter.
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int DIG_W = 64;                       // digest width
  localparam int LEN_W = 5;                        // window length register width
  localparam logic [LEN_W-1:0] LEN_RESET = 5'd10;  // window length after reset

  // Sequencer control of the shared compare unit
  typedef struct packed {
    logic clear;  // drop the hit flag for a new word
    logic en;     // read data is valid this cycle, compare it
  } cmp_ctl_t;

  // Per-word verdict from the sequencer
  typedef struct packed {
    logic fin;    // word done this cycle
    logic fwd;    // no match found
  } res_t;

endpackage

FILE: design/sliding_window_dedup_filter_unit.sv
// Top level of the sliding-window duplicate filter.
`timescale 1ns / 1ps
// Checks each 64-bit digest against the most recently forwarded digests (up to
// the programmed window length, capped at WINDOW_DEPTH) and reports forward=1
// for a new digest, forward=0 for a duplicate; new digests are appended to the
// ring, overwriting the oldest once it is full. A word is taken when start is
// high and busy is low. One compare unit walks the filled entries of the store
// RAM one per cycle, and busy stays high until the verdict is decided. The
// verdict is shown on out_forward/out_digest_out, with out_valid high for one
// cycle, in the same cycle as busy drops; the receiver cannot stall it. Writing
// cfg_wdata (only while idle) sets the window length (0 acts as 1) and empties
// the ring.
module sliding_window_dedup_filter_unit
  import sdf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [DIG_W-1:0] in_digest,
  output logic             out_valid,
  output logic             out_forward,
  output logic [DIG_W-1:0] out_digest_out,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

  logic [DIG_W-1:0] digest_r;
  logic             out_valid_r;
  logic             out_forward_r;
  logic [DIG_W-1:0] out_digest_r;

  cmp_ctl_t         cmp_ctl;
  res_t             res;
  logic             hit;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [DIG_W-1:0] rd_data;
  logic             accept;

  assign accept = start && !busy;

  sdf_seq #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .hit      (hit),
    .busy     (busy),
    .cmp_ctl  (cmp_ctl),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .res      (res)
  );

  sdf_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (cmp_ctl),
    .key    (digest_r),
    .rd_data(rd_data),
    .hit    (hit)
  );

  sdf_ram #(
    .WIDTH(DIG_W),
    .DEPTH(WINDOW_DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(digest_r),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      digest_r <= in_digest;
    end
    if (res.fin) begin
      out_forward_r <= res.fwd;
      out_digest_r  <= digest_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res.fin;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_forward    = out_forward_r;
  assign out_digest_out = out_digest_r;

  // a verdict only follows a cycle of work
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a preceding busy cycle");

  // an accepted word always raises busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // the ring is only appended for a forwarded word
  a_write_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> (out_valid && out_forward))
    else $error("store written without a forward verdict");

endmodule

FILE: design/sdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/sdf_cmp.sv
// Shared 64-bit equality unit with a sticky hit flag.
`timescale 1ns / 1ps
module sdf_cmp
  import sdf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cmp_ctl_t         ctl,
  input  logic [DIG_W-1:0] key,
  input  logic [DIG_W-1:0] rd_data,
  output logic             hit
);

  logic hit_r;
  logic hit_nxt;

  always_comb begin
    hit_nxt = hit_r;
    if (ctl.clear) begin
      hit_nxt = 1'b0;
    end else if (ctl.en && (rd_data == key)) begin
      hit_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= hit_nxt;
    end
  end

  assign hit = hit_r;

endmodule

FILE: design/sdf_seq.sv
// Scan sequencer: walks the filled ring entries, then decides and appends a new digest.
`timescale 1ns / 1ps
module sdf_seq
  import sdf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 16,
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata,
  input  logic             hit,
  output logic             busy,
  output cmp_ctl_t         cmp_ctl,
  output logic             rd_en,
  output logic [AW-1:0]    rd_addr,
  output logic             wr_en,
  output logic [AW-1:0]    wr_addr,
  output res_t             res
);

  localparam logic [LEN_W-1:0] DEPTH_CAP =
    (WINDOW_DEPTH > 31) ? LEN_W'(31) : LEN_W'(WINDOW_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic [LEN_W-1:0] slot_r, slot_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;

  logic [LEN_W-1:0] eff_len;
  logic [LEN_W-1:0] ws;
  logic [LEN_W:0]   ws_inc;
  logic             issue;

  always_comb begin
    eff_len = len_r;
    if (len_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_r > DEPTH_CAP) begin
      eff_len = DEPTH_CAP;
    end
    ws     = (slot_r >= eff_len) ? '0 : slot_r;
    ws_inc = {1'b0, ws} + (LEN_W+1)'(1);
  end

  assign issue = (idx_r < fill_r);

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    len_nxt   = len_r;
    cmp_ctl   = '0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    res       = '0;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt     = ST_SCAN;
          idx_nxt       = '0;
          pend_nxt      = 1'b0;
          cmp_ctl.clear = 1'b1;
        end
      end
      ST_SCAN: begin
        // read of entry idx issues now, its compare lands next cycle
        cmp_ctl.en = pend_r;
        rd_en      = issue;
        pend_nxt   = issue;
        if (issue) begin
          idx_nxt = idx_r + LEN_W'(1);
        end
        if (!issue && !pend_r) begin
          res.fin   = 1'b1;
          res.fwd   = !hit;
          state_nxt = ST_IDLE;
          if (!hit) begin
            wr_en    = 1'b1;
            slot_nxt = (ws_inc >= {1'b0, eff_len}) ? '0 : ws_inc[LEN_W-1:0];
            if (fill_r < eff_len) begin
              fill_nxt = fill_r + LEN_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // new geometry empties the ring
    if (cfg_we) begin
      len_nxt  = cfg_wdata;
      fill_nxt = '0;
      slot_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
      pend_r  <= 1'b0;
      fill_r  <= '0;
      slot_r  <= '0;
      len_r   <= LEN_RESET;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      len_r   <= len_nxt;
    end
  end

  assign busy    = (state_r != ST_IDLE);
  assign rd_addr = AW'(idx_r);
  assign wr_addr = AW'(ws);

endmodule
